/* hw/rtl/lss_pkg.sv */
// Package for the LIFO stack with search: action codes, result status codes
// and the payload widths shared by the stack RTL.
// Depends on nothing.
package lss_pkg;

  localparam int unsigned WordWidth   = 32;
  localparam int unsigned ActionWidth = 2;
  localparam int unsigned StatusWidth = 3;

  typedef logic [ActionWidth-1:0] action_t;
  typedef logic [StatusWidth-1:0] status_t;
  typedef logic [WordWidth-1:0]   word_t;

  localparam action_t ACT_PUSH   = 2'd0;
  localparam action_t ACT_POP    = 2'd1;
  localparam action_t ACT_LIST   = 2'd2;
  localparam action_t ACT_SEARCH = 2'd3;

  localparam status_t ST_POPPED     = 3'd0;
  localparam status_t ST_POP_EMPTY  = 3'd1;
  localparam status_t ST_LISTED     = 3'd2;
  localparam status_t ST_LIST_EMPTY = 3'd3;
  localparam status_t ST_FOUND      = 3'd4;
  localparam status_t ST_NOT_FOUND  = 3'd5;
  localparam status_t ST_PUSH_FULL  = 3'd6;

endpackage

/* hw/rtl/lss_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module lss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/lifo_stack_with_search_unit.sv */
// Top level of the LIFO stack with search: command port, sequencer and the
// compare unit that walks the stack memory one word per cycle.
// Depends on lss_pkg and lss_ram.
//
// A command is taken when start is high and busy is low. A push that fits
// gives no result and leaves busy low, so another command may follow at
// once. A pop reads the top word and returns it from the S_POP state. A list
// walks every stored word and a search each word in turn, both from the top
// down, the search until a match. The stack memory has a single read port
// whose registered read yields one word per cycle. Every other command gives
// one result. Each result is on status, data_out and last for exactly one
// cycle while strobe is high; the receiver cannot stall, so a list delivers
// one word every cycle with last high on the bottom word.
module lifo_stack_with_search_unit
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic [2:0]         status,
  output logic signed [31:0] data_out,
  output logic               last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CntOne = CW'(1);
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);
  localparam logic [AW-1:0] PtrOne = AW'(1);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_LIST, S_SRCH} state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [AW-1:0] ptr;
  word_t         key;

  logic          accept;
  logic [CW-1:0] count_m1;
  logic          we;
  logic [AW-1:0] raddr;
  word_t         rdata;
  logic          match;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign count_m1 = count - CntOne;
  assign we       = accept && (action == ACT_PUSH) && (count != CntFull);
  assign raddr    = (state == S_IDLE) ? count_m1[AW-1:0] : (ptr - PtrOne);
  assign match    = (rdata == key);

  lss_ram #(
    .WIDTH(WordWidth),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(count[AW-1:0]),
    .wdata($unsigned(value)),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      status   <= ST_NOT_FOUND;
      data_out <= '0;
      last     <= 1'b1;
      case (state)
        S_IDLE: begin
          if (accept) begin
            ptr <= count_m1[AW-1:0];
            key <= $unsigned(value);
            case (action)
              ACT_PUSH: begin
                if (count == CntFull) begin
                  strobe <= 1'b1;
                  status <= ST_PUSH_FULL;
                end else begin
                  count <= count + CntOne;
                end
              end
              ACT_POP: begin
                if (count == '0) begin
                  strobe <= 1'b1;
                  status <= ST_POP_EMPTY;
                end else begin
                  count <= count_m1;
                  state <= S_POP;
                end
              end
              ACT_LIST: begin
                if (count == '0) begin
                  strobe <= 1'b1;
                  status <= ST_LIST_EMPTY;
                end else begin
                  state <= S_LIST;
                end
              end
              default: begin
                if (count == '0) begin
                  strobe <= 1'b1;
                  status <= ST_NOT_FOUND;
                end else begin
                  state <= S_SRCH;
                end
              end
            endcase
          end
        end
        S_POP: begin
          strobe   <= 1'b1;
          status   <= ST_POPPED;
          data_out <= $signed(rdata);
          state    <= S_IDLE;
        end
        S_LIST: begin
          strobe   <= 1'b1;
          status   <= ST_LISTED;
          data_out <= $signed(rdata);
          last     <= (ptr == '0);
          ptr      <= ptr - PtrOne;
          if (ptr == '0) begin
            state <= S_IDLE;
          end
        end
        S_SRCH: begin
          ptr <= ptr - PtrOne;
          if (match) begin
            strobe <= 1'b1;
            status <= ST_FOUND;
            state  <= S_IDLE;
          end else if (ptr == '0) begin
            strobe <= 1'b1;
            status <= ST_NOT_FOUND;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntFull)
    else $error("stack count exceeds depth");

  a_push_silent: assert property (@(posedge clk) disable iff (rst)
    accept && (action == ACT_PUSH) && (count != CntFull) |=> !strobe && (count != '0))
    else $error("push that fits produced a result");

  a_not_last_is_list: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> (status == ST_LISTED) && (state == S_LIST))
    else $error("non-final result outside a list");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != ST_POPPED) && (status != ST_LISTED) |-> (data_out == '0))
    else $error("data_out not zero on a status-only result");
`endif

endmodule

/* dv/lifo_stack_with_search_unit_tb.sv */
// Self-checking testbench for lifo_stack_with_search_unit: directed and random command
// streams across several sender idle rates, each result checked against a behavioral stack.
// Depends on lss_pkg and the lifo_stack_with_search_unit RTL.
module lifo_stack_with_search_unit_tb
  import lss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StackDepth = 64;
  localparam int QuietLimit = 2000;
  localparam int TailCycles = 100;

  typedef struct {
    action_t     act;
    word_t       val;
    int unsigned idle_pct;
    bit          drain;
  } stack_cmd_t;

  typedef struct {
    status_t st;
    word_t   word;
    logic    fin;
  } stack_result_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          action;
  logic signed [31:0]  value;
  logic                strobe;
  logic [2:0]          status;
  logic signed [31:0]  data_out;
  logic                last;

  stack_cmd_t    pending_cmds[$];
  stack_result_t expected_results[$];
  word_t         plan_words[$];

  word_t stack_words[StackDepth];
  int    stack_level;
  int    peak_level;
  int    full_refusals;
  int    cmds_total;
  int    cmds_done;
  int    results_checked;
  int    error_count;
  int    quiet_cycles;
  logic  cmd_taken;
  logic  timed_out;

  lifo_stack_with_search_unit #(
    .DEPTH(StackDepth)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .action  (action),
    .value   (value),
    .strobe  (strobe),
    .status  (status),
    .data_out(data_out),
    .last    (last)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_cmd(action_t act, word_t val, int unsigned idle_pct, bit drain);
    stack_cmd_t c;
    c.act      = act;
    c.val      = val;
    c.idle_pct = idle_pct;
    c.drain    = drain;
    pending_cmds.push_back(c);
    cmds_total++;
    if (act == ACT_PUSH && plan_words.size() < StackDepth) begin
      plan_words.push_back(val);
    end else if (act == ACT_POP && plan_words.size() > 0) begin
      void'(plan_words.pop_back());
    end
  endtask

  task automatic add_search(int unsigned idle_pct, bit drain);
    word_t key;
    if (plan_words.size() > 0 && $urandom_range(0, 1) == 1) begin
      key = plan_words[$urandom_range(0, plan_words.size() - 1)];
    end else begin
      key = pick_word();
    end
    add_cmd(ACT_SEARCH, key, idle_pct, drain);
  endtask

  task automatic add_mixed(int count, int unsigned idle_pct);
    int unsigned push_w;
    int unsigned pop_w;
    int unsigned list_w;
    int unsigned roll;
    bit          drain;
    for (int n = 0; n < count; n++) begin
      if (n % 8 == 0) begin
        case ($urandom_range(0, 2))
          0: begin push_w = 60; pop_w = 10; list_w = 10; end
          1: begin push_w = 15; pop_w = 55; list_w = 10; end
          default: begin push_w = 30; pop_w = 25; list_w = 15; end
        endcase
      end
      drain = (n == 0) || ($urandom_range(0, 99) < 4);
      roll  = $urandom_range(0, 99);
      if (roll < push_w) begin
        add_cmd(ACT_PUSH, pick_word(), idle_pct, drain);
      end else if (roll < push_w + pop_w) begin
        add_cmd(ACT_POP, pick_word(), idle_pct, drain);
      end else if (roll < push_w + pop_w + list_w) begin
        add_cmd(ACT_LIST, pick_word(), idle_pct, drain);
      end else begin
        add_search(idle_pct, drain);
      end
    end
  endtask

  task automatic expect_result(status_t st, word_t word, logic fin);
    stack_result_t r;
    r.st   = st;
    r.word = word;
    r.fin  = fin;
    expected_results.push_back(r);
  endtask

  task automatic apply_stack_cmd(action_t act, word_t val);
    logic hit;
    case (act)
      ACT_PUSH: begin
        if (stack_level >= StackDepth) begin
          expect_result(ST_PUSH_FULL, '0, 1'b1);
          full_refusals++;
        end else begin
          stack_words[stack_level] = val;
          stack_level++;
          if (stack_level > peak_level) peak_level = stack_level;
        end
      end
      ACT_POP: begin
        if (stack_level == 0) begin
          expect_result(ST_POP_EMPTY, '0, 1'b1);
        end else begin
          stack_level--;
          expect_result(ST_POPPED, stack_words[stack_level], 1'b1);
        end
      end
      ACT_LIST: begin
        if (stack_level == 0) begin
          expect_result(ST_LIST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = stack_level; i > 0; i--) begin
            expect_result(ST_LISTED, stack_words[i-1], i == 1);
          end
        end
      end
      default: begin
        hit = 1'b0;
        for (int i = 0; i < stack_level; i++) begin
          if (stack_words[i] == val) hit = 1'b1;
        end
        expect_result(hit ? ST_FOUND : ST_NOT_FOUND, '0, 1'b1);
      end
    endcase
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (pending_cmds[0].drain && expected_results.size() != 0) begin
        start <= 1'b0;
      end else if ($urandom_range(0, 99) < pending_cmds[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        start  <= 1'b1;
        action <= pending_cmds[0].act;
        value  <= pending_cmds[0].val;
        void'(pending_cmds.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    stack_result_t want;
    cmd_taken <= !rst && start && !busy;
    if (!rst) begin
      if (strobe) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("Unexpected result transfer: status %0d, data_out %h, last %b",
                 status, data_out, last);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            error_count++;
          end
          if (data_out !== want.word) begin
            $error("data_out: expected %h, got %h", want.word, data_out);
            error_count++;
          end
          if (last !== want.fin) begin
            $error("last: expected %b, got %b", want.fin, last);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        cmds_done++;
        apply_stack_cmd(action, value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QuietLimit) timed_out <= 1'b1;
    end
  end

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    action          = ACT_PUSH;
    value           = '0;
    cmd_taken       = 1'b0;
    timed_out       = 1'b0;
    quiet_cycles    = 0;
    stack_level     = 0;
    peak_level      = 0;
    full_refusals   = 0;
    cmds_total      = 0;
    cmds_done       = 0;
    results_checked = 0;
    error_count     = 0;

    // Directed commands: empty-stack corner cases, extreme words, deep and missed searches.
    add_cmd(ACT_POP,    32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_LIST,   32'hFFFF_FFFF, 0, 1'b0);
    add_cmd(ACT_SEARCH, 32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_PUSH,   32'h7FFF_FFFF, 0, 1'b0);
    add_cmd(ACT_PUSH,   32'h8000_0000, 0, 1'b0);
    add_cmd(ACT_PUSH,   32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_PUSH,   32'hFFFF_FFFF, 0, 1'b0);
    add_cmd(ACT_PUSH,   32'h0000_0001, 0, 1'b0);
    add_cmd(ACT_SEARCH, 32'h8000_0000, 0, 1'b0);
    add_cmd(ACT_SEARCH, 32'h7FFF_FFFF, 0, 1'b0);
    add_cmd(ACT_SEARCH, 32'hFFFF_FFFE, 0, 1'b0);
    add_cmd(ACT_LIST,   32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_POP,    32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_SEARCH, 32'h0000_0001, 0, 1'b0);
    add_cmd(ACT_POP,    32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_POP,    32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_LIST,   32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_POP,    32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_POP,    32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_POP,    32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_LIST,   32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_SEARCH, 32'hFFFF_FFFF, 0, 1'b0);

    // Fill to capacity, then push past it and walk the full stack.
    add_cmd(ACT_PUSH, pick_word(), 0, 1'b1);
    while (plan_words.size() < StackDepth) add_cmd(ACT_PUSH, pick_word(), 0, 1'b0);
    add_cmd(ACT_PUSH, pick_word(), 0, 1'b0);
    add_cmd(ACT_PUSH, pick_word(), 0, 1'b0);
    add_cmd(ACT_LIST, 32'h0000_0000, 0, 1'b0);
    add_cmd(ACT_SEARCH, plan_words[0], 0, 1'b0);
    add_cmd(ACT_SEARCH, plan_words[StackDepth-1], 0, 1'b0);
    add_search(0, 1'b0);
    for (int n = 0; n < 8; n++) add_cmd(ACT_POP, pick_word(), 0, 1'b0);

    add_mixed(15, 0);
    add_mixed(45, 80);
    add_mixed(40, 38);
    add_mixed(10, 0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (!timed_out && !(cmds_done == cmds_total && expected_results.size() == 0)) begin
      @(negedge clk);
    end
    if (!timed_out) repeat (TailCycles) @(negedge clk);

    if (timed_out) $error("No transfer for %0d cycles", QuietLimit);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    $display("Run covered %0d commands and %0d checked results, peak depth %0d of %0d,",
             cmds_done, results_checked, peak_level, StackDepth);
    $display("with %0d refused pushes and sender idle rates of 0, 38 and 80 percent.",
             full_refusals);
    if (!timed_out && error_count == 0) begin
      $display("lifo_stack_with_search_unit test passed");
    end else begin
      $display("lifo_stack_with_search_unit test failed");
    end
    $finish;
  end

endmodule
